@@ rtl/ble_adv_structure_parser_unit_assert.svh @@
// Assertion macros used by the advertising parser RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef BLE_ADV_STRUCTURE_PARSER_UNIT_ASSERT_SVH
`define BLE_ADV_STRUCTURE_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BAP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bap assertion failed");

// Next-cycle implication.
`define BAP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bap assertion failed");

`endif

@@ rtl/bap_pkg.sv @@
// Shared types and constants for the advertising structure parser.
// No dependencies.
package bap_pkg;

    // AD type codes
    localparam logic [7:0] AD_UUID16_PART   = 8'h02;
    localparam logic [7:0] AD_UUID16_ALL    = 8'h03;
    localparam logic [7:0] AD_UUID128_PART  = 8'h06;
    localparam logic [7:0] AD_UUID128_ALL   = 8'h07;
    localparam logic [7:0] AD_SHORT_NAME    = 8'h08;
    localparam logic [7:0] AD_COMPLETE_NAME = 8'h09;
    localparam logic [7:0] AD_SVC_DATA      = 8'h16;
    localparam logic [7:0] AD_MFR_DATA      = 8'hFF;

    // event codes
    localparam logic [3:0] EV_NAME_BEGIN  = 4'd0;
    localparam logic [3:0] EV_NAME_BYTE   = 4'd1;
    localparam logic [3:0] EV_UUID16      = 4'd2;
    localparam logic [3:0] EV_UUID128     = 4'd3;
    localparam logic [3:0] EV_SDATA_BEGIN = 4'd4;
    localparam logic [3:0] EV_SDATA_BYTE  = 4'd5;
    localparam logic [3:0] EV_MFR_BEGIN   = 4'd6;
    localparam logic [3:0] EV_MFR_BYTE    = 4'd7;
    localparam logic [3:0] EV_SUMMARY     = 4'd8;

    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_TYPE  = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [7:0]  value_byte;
        logic [63:0] uuid_low;
        logic [63:0] uuid_high;
        logic        saw_short_name;
        logic        saw_complete_name;
        logic        end_of_payload;
    } res_t;

    // results of one processed byte: an optional event, then an optional summary
    typedef struct packed {
        logic ev_valid;
        res_t ev;
        logic sum_valid;
        res_t sum;
    } step_t;

endpackage

@@ rtl/bap_in_if.sv @@
// Byte request channel of the advertising parser.
// No dependencies.
interface bap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;
    logic [4:0] adv_length;

    modport source (output valid, output data_byte, output first, output adv_length,
                    input ready);
    modport sink   (input valid, input data_byte, input first, input adv_length,
                    output ready);
endinterface

@@ rtl/bap_res_if.sv @@
// Result request channel of the advertising parser.
// No dependencies.
interface bap_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [7:0]  value_byte;
    logic [63:0] uuid_low;
    logic [63:0] uuid_high;
    logic        saw_short_name;
    logic        saw_complete_name;
    logic        end_of_payload;

    modport source (output valid, output event_res, output value_byte, output uuid_low,
                    output uuid_high, output saw_short_name, output saw_complete_name,
                    output end_of_payload, input ready);
    modport sink   (input valid, input event_res, input value_byte, input uuid_low,
                    input uuid_high, input saw_short_name, input saw_complete_name,
                    input end_of_payload, output ready);
endinterface

@@ rtl/bap_parser_core.sv @@
// Input register, parser state and per-byte decode of the AD structure walk.
// Depends on bap_pkg and bap_in_if.
module bap_parser_core
(
    input  logic           clk,
    input  logic           rst_n,
    bap_in_if.sink         byte_ch,
    input  logic           room,
    output bap_pkg::step_t step
);

    typedef struct packed {
        logic [4:0]      pos;
        logic [4:0]      total;
        bap_pkg::phase_t phase;
        logic [4:0]      rem;
        logic [7:0]      ftype;
        logic            stopped;
        logic            taking;
        logic            nonempty;
        logic            short_seen;
        logic            complete_seen;
        logic [127:0]    uuid;
        logic [3:0]      ucnt;
        logic            fwd;
    } pstate_t;

    logic       item_valid_reg;
    logic [7:0] item_byte_reg;
    logic       item_first_reg;
    logic [4:0] item_len_reg;
    logic       process;

    pstate_t st_reg;
    pstate_t st_next;
    pstate_t st_eff;

    assign process       = item_valid_reg && room;
    assign byte_ch.ready = !item_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            item_valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            item_byte_reg  <= byte_ch.data_byte;
            item_first_reg <= byte_ch.first;
            item_len_reg   <= byte_ch.adv_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (process)
        begin
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        logic [7:0]   b;
        logic [8:0]   end_pos;
        logic [4:0]   rem_t;
        logic         c16;
        logic [127:0] u;

        b       = item_byte_reg;
        end_pos = '0;
        rem_t   = '0;
        c16     = 1'b0;
        u       = '0;

        // first byte restarts the walk; the 5-bit length is already within range
        if (item_first_reg)
        begin
            st_eff       = '0;
            st_eff.total = item_len_reg;
        end
        else
        begin
            st_eff = st_reg;
        end

        st_next        = st_eff;
        step           = '0;
        step.ev_valid  = 1'b0;
        step.sum_valid = 1'b0;

        if (st_eff.pos < st_eff.total)
        begin
            st_next.pos = st_eff.pos + 5'd1;
            if (!st_eff.stopped)
            begin
                unique case (st_eff.phase)
                    bap_pkg::PH_LEN:
                    begin
                        end_pos = 9'(st_eff.pos) + 9'd1 + 9'(b);
                        if (b == 8'd0 || end_pos > 9'(st_eff.total))
                        begin
                            st_next.stopped = 1'b1;
                        end
                        else
                        begin
                            st_next.rem   = b[4:0];
                            st_next.phase = bap_pkg::PH_TYPE;
                        end
                    end
                    bap_pkg::PH_TYPE:
                    begin
                        rem_t          = st_eff.rem - 5'd1;
                        st_next.ftype  = b;
                        st_next.rem    = rem_t;
                        st_next.taking = 1'b0;
                        st_next.fwd    = 1'b0;
                        st_next.ucnt   = '0;
                        st_next.uuid   = '0;
                        case (b)
                            bap_pkg::AD_SHORT_NAME:
                            begin
                                st_next.short_seen = 1'b1;
                                if (!st_eff.nonempty)
                                begin
                                    st_next.taking       = 1'b1;
                                    st_next.nonempty     = rem_t != 5'd0;
                                    step.ev_valid        = 1'b1;
                                    step.ev.event_res    = bap_pkg::EV_NAME_BEGIN;
                                end
                            end
                            bap_pkg::AD_COMPLETE_NAME:
                            begin
                                st_next.complete_seen = 1'b1;
                                st_next.taking        = 1'b1;
                                st_next.nonempty      = rem_t != 5'd0;
                                step.ev_valid         = 1'b1;
                                step.ev.event_res     = bap_pkg::EV_NAME_BEGIN;
                            end
                            bap_pkg::AD_SVC_DATA:
                            begin
                                if (rem_t >= 5'd2)
                                begin
                                    st_next.fwd       = 1'b1;
                                    step.ev_valid     = 1'b1;
                                    step.ev.event_res = bap_pkg::EV_SDATA_BEGIN;
                                end
                            end
                            bap_pkg::AD_MFR_DATA:
                            begin
                                st_next.fwd       = 1'b1;
                                step.ev_valid     = 1'b1;
                                step.ev.event_res = bap_pkg::EV_MFR_BEGIN;
                            end
                            default:
                            begin
                            end
                        endcase
                        st_next.phase = (rem_t == 5'd0) ? bap_pkg::PH_LEN
                                                        : bap_pkg::PH_VALUE;
                    end
                    default:
                    begin
                        if (st_eff.rem != 5'd0)
                        begin
                            st_next.rem = st_eff.rem - 5'd1;
                        end
                        case (st_eff.ftype) inside
                            bap_pkg::AD_SHORT_NAME, bap_pkg::AD_COMPLETE_NAME:
                            begin
                                if (st_eff.taking)
                                begin
                                    step.ev_valid      = 1'b1;
                                    step.ev.event_res  = bap_pkg::EV_NAME_BYTE;
                                    step.ev.value_byte = b;
                                end
                            end
                            bap_pkg::AD_UUID16_PART, bap_pkg::AD_UUID16_ALL:
                            begin
                                c16 = st_eff.ucnt[0];
                                u   = st_eff.uuid | (128'(b) << (c16 ? 7'd8 : 7'd0));
                                if (c16)
                                begin
                                    step.ev_valid     = 1'b1;
                                    step.ev.event_res = bap_pkg::EV_UUID16;
                                    step.ev.uuid_low  = u[63:0];
                                    st_next.uuid      = '0;
                                    st_next.ucnt      = '0;
                                end
                                else
                                begin
                                    st_next.uuid = u;
                                    st_next.ucnt = 4'd1;
                                end
                            end
                            bap_pkg::AD_UUID128_PART, bap_pkg::AD_UUID128_ALL:
                            begin
                                u = st_eff.uuid | (128'(b) << {st_eff.ucnt, 3'b000});
                                if (st_eff.ucnt == 4'd15)
                                begin
                                    step.ev_valid     = 1'b1;
                                    step.ev.event_res = bap_pkg::EV_UUID128;
                                    step.ev.uuid_low  = u[63:0];
                                    step.ev.uuid_high = u[127:64];
                                    st_next.uuid      = '0;
                                    st_next.ucnt      = '0;
                                end
                                else
                                begin
                                    st_next.uuid = u;
                                    st_next.ucnt = st_eff.ucnt + 4'd1;
                                end
                            end
                            bap_pkg::AD_SVC_DATA:
                            begin
                                if (st_eff.fwd)
                                begin
                                    step.ev_valid      = 1'b1;
                                    step.ev.event_res  = bap_pkg::EV_SDATA_BYTE;
                                    step.ev.value_byte = b;
                                end
                            end
                            bap_pkg::AD_MFR_DATA:
                            begin
                                if (st_eff.fwd)
                                begin
                                    step.ev_valid      = 1'b1;
                                    step.ev.event_res  = bap_pkg::EV_MFR_BYTE;
                                    step.ev.value_byte = b;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                        if (st_next.rem == 5'd0)
                        begin
                            st_next.phase = bap_pkg::PH_LEN;
                        end
                    end
                endcase
            end

            // last byte of the payload closes with a summary
            if (st_eff.pos + 5'd1 == st_eff.total)
            begin
                step.sum_valid             = 1'b1;
                step.sum.event_res         = bap_pkg::EV_SUMMARY;
                step.sum.saw_short_name    = st_next.short_seen;
                step.sum.saw_complete_name = st_next.complete_seen;
                step.sum.end_of_payload    = 1'b1;
            end
        end

        if (!process)
        begin
            step.ev_valid  = 1'b0;
            step.sum_valid = 1'b0;
        end
    end

endmodule

@@ rtl/bap_result_buf.sv @@
// Result register plus one spare slot for a trailing summary.
// Depends on bap_pkg, bap_res_if and the assertion header.
`include "ble_adv_structure_parser_unit_assert.svh"

module bap_result_buf
(
    input  logic           clk,
    input  logic           rst_n,
    input  bap_pkg::step_t step,
    output logic           room,
    bap_res_if.source      result_ch
);

    logic          out_valid_reg;
    logic          spare_valid_reg;
    bap_pkg::res_t out_reg;
    bap_pkg::res_t spare_reg;
    logic          pop;

    assign pop  = out_valid_reg && result_ch.ready;
    // a byte may bring two results, so both slots must be free after this edge
    assign room = !spare_valid_reg && (!out_valid_reg || result_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (room)
        begin
            out_valid_reg   <= step.ev_valid || step.sum_valid;
            spare_valid_reg <= step.ev_valid && step.sum_valid;
        end
        else if (pop)
        begin
            out_valid_reg   <= spare_valid_reg;
            spare_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room)
        begin
            out_reg   <= step.ev_valid ? step.ev : step.sum;
            spare_reg <= step.sum;
        end
        else if (pop)
        begin
            out_reg <= spare_reg;
        end
    end

    assign result_ch.valid             = out_valid_reg;
    assign result_ch.event_res         = out_reg.event_res;
    assign result_ch.value_byte        = out_reg.value_byte;
    assign result_ch.uuid_low          = out_reg.uuid_low;
    assign result_ch.uuid_high         = out_reg.uuid_high;
    assign result_ch.saw_short_name    = out_reg.saw_short_name;
    assign result_ch.saw_complete_name = out_reg.saw_complete_name;
    assign result_ch.end_of_payload    = out_reg.end_of_payload;

    `BAP_ASSERT_IMP(a_spare_behind_out, spare_valid_reg, out_valid_reg)
    `BAP_ASSERT_IMP(a_push_needs_room, step.ev_valid || step.sum_valid, room)
    `BAP_ASSERT_IMP(a_spare_is_summary, spare_valid_reg, spare_reg.end_of_payload)
    `BAP_ASSERT_NXT(a_spare_drains, spare_valid_reg && result_ch.ready, !spare_valid_reg)

endmodule

@@ rtl/ble_adv_structure_parser_unit.sv @@
// BLE advertising AD structure parser, top level.
// Channels: byte_ch (sink) takes one payload byte per request with first and
// adv_length; result_ch (source) gives one event per request.
// A byte registers in the input register on acceptance and is decoded
// against the parser state; its results load into the result register at
// an edge where the result side has room, and drive result_ch from there.
// Throughput: one byte per cycle while result_ch is ready and each byte
// yields at most one result. The last byte of a payload may yield an event
// and a summary, held in a spare slot; the byte side waits while it drains.
// The result register and the spare slot decouple the two sides: a new byte
// is taken while a finished result is still waiting to be taken.
// A stalled receiver holds the result and the byte input register; ready on
// byte_ch drops once the input register holds an undecoded byte.
// Reset clears the parser to "expect length byte", empty name state and no
// payload; bytes arriving before a first byte give no result.
// Depends on bap_pkg, bap_in_if, bap_res_if, bap_parser_core, bap_result_buf.
module ble_adv_structure_parser_unit
(
    input  logic      clk,
    input  logic      rst_n,
    bap_in_if.sink    byte_ch,
    bap_res_if.source result_ch
);

    // decoded results of the byte in the input register
    bap_pkg::step_t step;
    // result side can take up to two results this edge
    logic           room;

    bap_parser_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .room    (room),
        .step    (step)
    );

    bap_result_buf u_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .room      (room),
        .result_ch (result_ch)
    );

endmodule
